### sv/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg
// Types and constants shared by the instruction execute unit.
// ----------------------------------------------------------------------------
package rie_pkg;

  localparam int unsigned PcBits   = 12;
  localparam int unsigned RegCount = 16;
  localparam int unsigned RegIdxW  = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ImmW     = 12;
  localparam int unsigned OpW      = 8;
  localparam int unsigned ShW      = 5;

  localparam logic [RegIdxW-1:0] RegZero = 4'd0;
  localparam logic [RegIdxW-1:0] RegImm  = 4'd1;
  localparam logic [RegIdxW-1:0] RegLink = 4'd15;

  typedef enum logic [OpW-1:0] {
    OpAdd  = 8'd0,
    OpSub  = 8'd1,
    OpAnd  = 8'd2,
    OpOr   = 8'd3,
    OpXor  = 8'd4,
    OpMul  = 8'd5,
    OpSll  = 8'd6,
    OpSra  = 8'd7,
    OpSrl  = 8'd8,
    OpBeq  = 8'd9,
    OpBne  = 8'd10,
    OpBlt  = 8'd11,
    OpBgt  = 8'd12,
    OpBle  = 8'd13,
    OpBge  = 8'd14,
    OpJal  = 8'd15,
    OpHalt = 8'd20
  } op_e;

  // register file write port
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } rie_wr_t;

endpackage

### sv/rie_regfile.sv
// ----------------------------------------------------------------------------
// rie_regfile
// 16 x 32 register file held as two copies, each with registered reads and
// forwarding of the write made at the same edge. Unwritten entries read zero.
// ----------------------------------------------------------------------------
module rie_regfile (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [rie_pkg::RegIdxW-1:0] rd_a_idx_i,
  input  logic [rie_pkg::RegIdxW-1:0] rd_b_idx_i,
  input  logic [rie_pkg::RegIdxW-1:0] rd_d_idx_i,
  input  rie_pkg::rie_wr_t            wr_i,
  output logic [rie_pkg::DataW-1:0]   rd_a_data_o,
  output logic [rie_pkg::DataW-1:0]   rd_b_data_o,
  output logic [rie_pkg::DataW-1:0]   rd_d_data_o
);
  import rie_pkg::*;

  logic [DataW-1:0]    mem_ab [RegCount];
  logic [DataW-1:0]    mem_d  [RegCount];
  logic [RegCount-1:0] vld_q, vld_d;
  logic [DataW-1:0]    rd_a_q, rd_b_q, rd_d_q;

  always_comb begin
    vld_d = vld_q;
    if (wr_i.en) begin
      vld_d[wr_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // copy serving the two source operands
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_ab[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.idx == rd_a_idx_i)) begin
        rd_a_q <= wr_i.data;
      end else begin
        rd_a_q <= vld_q[rd_a_idx_i] ? mem_ab[rd_a_idx_i] : '0;
      end
      if (wr_i.en && (wr_i.idx == rd_b_idx_i)) begin
        rd_b_q <= wr_i.data;
      end else begin
        rd_b_q <= vld_q[rd_b_idx_i] ? mem_ab[rd_b_idx_i] : '0;
      end
    end
  end

  // copy serving the branch target register
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_d[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.idx == rd_d_idx_i)) begin
        rd_d_q <= wr_i.data;
      end else begin
        rd_d_q <= vld_q[rd_d_idx_i] ? mem_d[rd_d_idx_i] : '0;
      end
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;
  assign rd_d_data_o = rd_d_q;

endmodule

### sv/rie_exec.sv
// ----------------------------------------------------------------------------
// rie_exec
// ALU, branch compare, jal link and next pc selection for one instruction.
// ----------------------------------------------------------------------------
module rie_exec #(
  parameter int unsigned PC_BITS = rie_pkg::PcBits
) (
  input  logic [rie_pkg::OpW-1:0]     opcode_i,
  input  logic [rie_pkg::RegIdxW-1:0] dest_reg_i,
  input  logic [rie_pkg::RegIdxW-1:0] src_a_reg_i,
  input  logic [rie_pkg::RegIdxW-1:0] src_b_reg_i,
  input  logic [rie_pkg::ImmW-1:0]    immediate_i,
  input  logic [PC_BITS-1:0]          current_pc_i,
  input  logic [rie_pkg::DataW-1:0]   rf_a_i,
  input  logic [rie_pkg::DataW-1:0]   rf_b_i,
  input  logic [rie_pkg::DataW-1:0]   rf_d_i,
  output logic [PC_BITS-1:0]          next_pc_o,
  output logic                        taken_o,
  output logic                        halted_o,
  output rie_pkg::rie_wr_t            wr_o
);
  import rie_pkg::*;

  logic [DataW-1:0]   imm_ext;
  logic [DataW-1:0]   a, b, d;
  logic [DataW-1:0]   alu_res;
  logic [ShW-1:0]     sh;
  logic [PC_BITS-1:0] seq_pc;
  logic [DataW-1:0]   seq_ext;
  logic               cond;
  op_e                op;

  assign op      = op_e'(opcode_i);
  assign imm_ext = {{(DataW-ImmW){immediate_i[ImmW-1]}}, immediate_i};
  assign seq_pc  = current_pc_i + 1'b1;
  assign seq_ext = {{(DataW-PC_BITS){1'b0}}, seq_pc};
  assign sh      = b[ShW-1:0];

  // register zero and the immediate register override the file
  always_comb begin
    priority if (src_a_reg_i == RegZero) a = '0;
    else if (src_a_reg_i == RegImm) a = imm_ext;
    else a = rf_a_i;
    priority if (src_b_reg_i == RegZero) b = '0;
    else if (src_b_reg_i == RegImm) b = imm_ext;
    else b = rf_b_i;
    priority if (dest_reg_i == RegZero) d = '0;
    else if (dest_reg_i == RegImm) d = imm_ext;
    else d = rf_d_i;
  end

  always_comb begin
    unique case (op)
      OpAdd:   alu_res = a + b;
      OpSub:   alu_res = a - b;
      OpAnd:   alu_res = a & b;
      OpOr:    alu_res = a | b;
      OpXor:   alu_res = a ^ b;
      OpMul:   alu_res = a * b;
      OpSll:   alu_res = a << sh;
      OpSra:   alu_res = $unsigned($signed(a) >>> sh);
      default: alu_res = a >> sh;
    endcase
  end

  always_comb begin
    unique case (op)
      OpBeq:   cond = (a == b);
      OpBne:   cond = (a != b);
      OpBlt:   cond = ($signed(a) < $signed(b));
      OpBgt:   cond = ($signed(b) < $signed(a));
      OpBle:   cond = !($signed(b) < $signed(a));
      default: cond = !($signed(a) < $signed(b));
    endcase
  end

  always_comb begin
    next_pc_o = seq_pc;
    taken_o   = 1'b0;
    halted_o  = 1'b0;
    wr_o      = '0;
    if (opcode_i <= OpSrl) begin
      if (dest_reg_i != RegZero) begin
        wr_o.en   = 1'b1;
        wr_o.idx  = dest_reg_i;
        wr_o.data = alu_res;
      end
    end else if (opcode_i <= OpBge) begin
      if (cond) begin
        next_pc_o = d[PC_BITS-1:0];
        taken_o   = 1'b1;
      end
    end else if (op == OpJal) begin
      wr_o.en   = 1'b1;
      wr_o.idx  = RegLink;
      wr_o.data = seq_ext;
      taken_o   = 1'b1;
      // target reads the link register after it is written
      next_pc_o = (dest_reg_i == RegLink) ? seq_pc : d[PC_BITS-1:0];
    end else if (op == OpHalt) begin
      next_pc_o = current_pc_i;
      halted_o  = 1'b1;
    end
  end

endmodule

### sv/risc_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// risc_instruction_execute_unit
// Executes one decoded instruction per transaction against a 16 x 32
// register file and reports the next pc, branch and write-back.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o   | opcode, regs, imm, pc
//  out     | output    | out_valid_o / out_stall_i | next pc, flags, write-back
//
//  one transaction per cycle while the output is not stalled; a result passes
//  through the operand read register, then the result register
//  the register file is written as the instruction enters the result register,
//  and that value is forwarded to the operand read made at the same edge
//  reset clears all valid flags and makes every register read zero
//  a stalled output holds the instruction in the operand stage, which then
//  stalls the input
// ----------------------------------------------------------------------------
module risc_instruction_execute_unit #(
  parameter int unsigned PC_BITS = rie_pkg::PcBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rie_pkg::OpW-1:0]       opcode_i,
  input  logic [rie_pkg::RegIdxW-1:0]   dest_reg_i,
  input  logic [rie_pkg::RegIdxW-1:0]   src_a_reg_i,
  input  logic [rie_pkg::RegIdxW-1:0]   src_b_reg_i,
  input  logic [rie_pkg::ImmW-1:0]      immediate_i,
  input  logic [PC_BITS-1:0]            current_pc_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [PC_BITS-1:0]            next_pc_o,
  output logic                          branch_taken_o,
  output logic                          halted_o,
  output logic                          write_valid_o,
  output logic [rie_pkg::RegIdxW-1:0]   write_index_o,
  output logic signed [rie_pkg::DataW-1:0] write_value_o
);
  import rie_pkg::*;

  logic               in_acc, s1_adv;
  logic               s1_valid_q, s1_valid_d;
  logic               out_valid_q, out_valid_d;
  logic [OpW-1:0]     op_q;
  logic [RegIdxW-1:0] rd_q, rs_q, rt_q;
  logic [ImmW-1:0]    imm_q;
  logic [PC_BITS-1:0] pc_q;
  logic [DataW-1:0]   rf_a, rf_b, rf_d;
  logic [PC_BITS-1:0] ex_next_pc;
  logic               ex_taken, ex_halted;
  rie_wr_t            ex_wr, rf_wr;
  logic [PC_BITS-1:0] next_pc_q;
  logic               taken_q, halted_q;
  rie_wr_t            wr_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      rd_q  <= dest_reg_i;
      rs_q  <= src_a_reg_i;
      rt_q  <= src_b_reg_i;
      imm_q <= immediate_i;
      pc_q  <= current_pc_i;
    end
  end

  always_comb begin
    rf_wr    = ex_wr;
    rf_wr.en = ex_wr.en && s1_adv;
  end

  rie_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_a_idx_i  (src_a_reg_i),
    .rd_b_idx_i  (src_b_reg_i),
    .rd_d_idx_i  (dest_reg_i),
    .wr_i        (rf_wr),
    .rd_a_data_o (rf_a),
    .rd_b_data_o (rf_b),
    .rd_d_data_o (rf_d)
  );

  rie_exec #(
    .PC_BITS (PC_BITS)
  ) u_exec (
    .opcode_i     (op_q),
    .dest_reg_i   (rd_q),
    .src_a_reg_i  (rs_q),
    .src_b_reg_i  (rt_q),
    .immediate_i  (imm_q),
    .current_pc_i (pc_q),
    .rf_a_i       (rf_a),
    .rf_b_i       (rf_b),
    .rf_d_i       (rf_d),
    .next_pc_o    (ex_next_pc),
    .taken_o      (ex_taken),
    .halted_o     (ex_halted),
    .wr_o         (ex_wr)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      next_pc_q <= ex_next_pc;
      taken_q   <= ex_taken;
      halted_q  <= ex_halted;
      wr_q      <= ex_wr;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = next_pc_q;
  assign branch_taken_o = taken_q;
  assign halted_o       = halted_q;
  assign write_valid_o  = wr_q.en;
  assign write_index_o  = wr_q.idx;
  assign write_value_o  = $signed(wr_q.data);

endmodule

### tb/tb_risc_instruction_execute_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_risc_instruction_execute_unit
// Drives decoded instructions into the execute unit with bursty input and a
// stalling receiver, keeps a shadow register file to work out each retired
// instruction, and compares every result field against it in order.
// ----------------------------------------------------------------------------
module tb_risc_instruction_execute_unit;
  import rie_pkg::*;

  localparam logic [OpW-1:0] OpUnusedLo  = 8'd16;
  localparam logic [OpW-1:0] OpUnusedMid = 8'd21;
  localparam logic [OpW-1:0] OpUnusedMax = 8'hFF;

  localparam int unsigned RandomItems = 950;
  localparam int unsigned HoldAt      = 300;
  localparam int unsigned HoldLen     = 150;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted  = 20;

  typedef enum logic [2:0] {
    RxFree, RxLight, RxHalf, RxToggle, RxHeavy
  } rx_mode_e;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [RegIdxW-1:0] rd;
    logic [RegIdxW-1:0] rs;
    logic [RegIdxW-1:0] rt;
    logic [ImmW-1:0]    imm;
    logic [PcBits-1:0]  pc;
  } instr_t;

  typedef struct packed {
    logic [PcBits-1:0]  next_pc;
    logic               taken;
    logic               halted;
    logic               wr_en;
    logic [RegIdxW-1:0] wr_idx;
    logic [DataW-1:0]   wr_val;
  } retire_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  instr_t in_item = '0;

  logic                      in_stall;
  logic                      out_valid;
  logic [PcBits-1:0]         next_pc;
  logic                      branch_taken;
  logic                      halted;
  logic                      write_valid;
  logic [RegIdxW-1:0]        write_index;
  logic signed [DataW-1:0]   write_value;

  instr_t  instr_backlog[$];
  retire_t retire_expected[$];
  logic [DataW-1:0] shadow_gpr [RegCount];

  bit       in_took    = 1'b0;
  int       gap_left   = 0;
  int       burst_left = 0;
  int       hold_left  = 0;
  int       rx_cycle   = 0;
  rx_mode_e rx_mode    = RxFree;

  int n_accepted = 0;
  int n_retired  = 0;
  int n_writes   = 0;
  int n_redirect = 0;
  int n_halts    = 0;
  int n_holds    = 0;
  int n_in_stall = 0;
  int mismatches = 0;
  int idle_count = 0;

  risc_instruction_execute_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (in_item.op),
    .dest_reg_i     (in_item.rd),
    .src_a_reg_i    (in_item.rs),
    .src_b_reg_i    (in_item.rt),
    .immediate_i    (in_item.imm),
    .current_pc_i   (in_item.pc),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .next_pc_o      (next_pc),
    .branch_taken_o (branch_taken),
    .halted_o       (halted),
    .write_valid_o  (write_valid),
    .write_index_o  (write_index),
    .write_value_o  (write_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // runs one instruction on the shadow register file
  function automatic retire_t execute_instr(instr_t ins);
    retire_t           res;
    logic [DataW-1:0]  a;
    logic [DataW-1:0]  b;
    logic [DataW-1:0]  r;
    logic [ShW-1:0]    sh;
    logic [PcBits-1:0] seq;
    logic              cond;
    res = '0;
    shadow_gpr[RegImm]  = {{(DataW-ImmW){ins.imm[ImmW-1]}}, ins.imm};
    shadow_gpr[RegZero] = '0;
    a   = shadow_gpr[ins.rs];
    b   = shadow_gpr[ins.rt];
    sh  = b[ShW-1:0];
    seq = ins.pc + 1'b1;
    res.next_pc = seq;
    if (ins.op <= OpSrl) begin
      case (ins.op)
        OpAdd:   r = a + b;
        OpSub:   r = a - b;
        OpAnd:   r = a & b;
        OpOr:    r = a | b;
        OpXor:   r = a ^ b;
        OpMul:   r = a * b;
        OpSll:   r = a << sh;
        OpSra:   r = $signed(a) >>> sh;
        default: r = a >> sh;
      endcase
      if (ins.rd != RegZero) begin
        shadow_gpr[ins.rd] = r;
        res.wr_en  = 1'b1;
        res.wr_idx = ins.rd;
        res.wr_val = r;
      end
    end else if (ins.op <= OpBge) begin
      case (ins.op)
        OpBeq:   cond = (a == b);
        OpBne:   cond = (a != b);
        OpBlt:   cond = ($signed(a) <  $signed(b));
        OpBgt:   cond = ($signed(a) >  $signed(b));
        OpBle:   cond = ($signed(a) <= $signed(b));
        default: cond = ($signed(a) >= $signed(b));
      endcase
      if (cond) begin
        res.next_pc = shadow_gpr[ins.rd][PcBits-1:0];
        res.taken   = 1'b1;
      end
    end else if (ins.op == OpJal) begin
      // link first, so a jump through the link register lands on pc+1
      shadow_gpr[RegLink] = {{(DataW-PcBits){1'b0}}, seq};
      res.wr_en   = 1'b1;
      res.wr_idx  = RegLink;
      res.wr_val  = shadow_gpr[RegLink];
      res.next_pc = shadow_gpr[ins.rd][PcBits-1:0];
      res.taken   = 1'b1;
    end else if (ins.op == OpHalt) begin
      res.next_pc = ins.pc;
      res.halted  = 1'b1;
    end
    return res;
  endfunction

  task automatic queue_instr(input logic [OpW-1:0] op, input logic [RegIdxW-1:0] rd,
                             input logic [RegIdxW-1:0] rs, input logic [RegIdxW-1:0] rt,
                             input logic [ImmW-1:0] imm, input logic [PcBits-1:0] pc);
    instr_t ins;
    ins = '{op: op, rd: rd, rs: rs, rt: rt, imm: imm, pc: pc};
    instr_backlog.push_back(ins);
  endtask

  function automatic instr_t random_instr();
    instr_t ins;
    int     sel;
    sel = $urandom_range(0, 99);
    if (sel < 45)      ins.op = OpW'($urandom_range(int'(OpAdd), int'(OpSrl)));
    else if (sel < 75) ins.op = OpW'($urandom_range(int'(OpBeq), int'(OpBge)));
    else if (sel < 83) ins.op = OpJal;
    else if (sel < 87) ins.op = OpHalt;
    else               ins.op = OpW'($urandom_range(0, 255));
    ins.rd = RegIdxW'($urandom_range(0, RegCount - 1));
    ins.rs = RegIdxW'($urandom_range(0, RegCount - 1));
    ins.rt = ($urandom_range(0, 5) == 0) ? ins.rs : RegIdxW'($urandom_range(0, RegCount - 1));
    case ($urandom_range(0, 7))
      0:       ins.imm = 12'h800;
      1:       ins.imm = 12'h7FF;
      2:       ins.imm = 12'hFFF;
      default: ins.imm = ImmW'($urandom_range(0, 4095));
    endcase
    ins.pc = ($urandom_range(0, 15) == 0) ? 12'hFFF : PcBits'($urandom_range(0, 4095));
    return ins;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch on result %0d, %s: got %h, expected %h", n_retired, what, got, want);
  endtask

  // input side: sender bursts with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (instr_backlog.size() != 0) begin
        in_item  <= instr_backlog.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  // output side: randomly chosen stall patterns, plus long hold-offs
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (n_holds < 2 && n_accepted >= HoldAt * (n_holds + 1)) begin
      out_stall <= 1'b1;
      hold_left = HoldLen - 1;
      n_holds++;
    end else begin
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 4));
      case (rx_mode)
        RxFree:   out_stall <= 1'b0;
        RxLight:  out_stall <= ($urandom_range(0, 3) == 0);
        RxHalf:   out_stall <= 1'($urandom_range(0, 1));
        RxToggle: out_stall <= rx_cycle[0];
        default:  out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // accepted instructions go through the shadow model
  always @(posedge clk) begin
    if (rst_n && in_valid) begin
      if (!in_stall) begin
        retire_expected.push_back(execute_instr(in_item));
        in_took = 1'b1;
        n_accepted++;
      end else begin
        n_in_stall++;
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    retire_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (retire_expected.size() == 0) begin
        report_mismatch("unexpected result, next_pc", DataW'(next_pc), '0);
      end else begin
        want = retire_expected.pop_front();
        if (next_pc !== want.next_pc)
          report_mismatch("next_pc", DataW'(next_pc), DataW'(want.next_pc));
        if (branch_taken !== want.taken)
          report_mismatch("branch_taken", DataW'(branch_taken), DataW'(want.taken));
        if (halted !== want.halted)
          report_mismatch("halted", DataW'(halted), DataW'(want.halted));
        if (write_valid !== want.wr_en)
          report_mismatch("write_valid", DataW'(write_valid), DataW'(want.wr_en));
        if (write_index !== want.wr_idx)
          report_mismatch("write_index", DataW'(write_index), DataW'(want.wr_idx));
        if (write_value !== want.wr_val)
          report_mismatch("write_value", write_value, want.wr_val);
        n_writes   += int'(want.wr_en);
        n_redirect += int'(want.taken);
        n_halts    += int'(want.halted);
      end
      n_retired++;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 IdleLimit, retire_expected.size());
        $display("risc_instruction_execute_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (shadow_gpr[i]) shadow_gpr[i] = '0;

    // directed: load extremes, every operation, branch corners, jal, halt and unused opcodes
    queue_instr(OpAdd, 4'd2, RegImm, RegZero, 12'h7FF, 12'h000);
    queue_instr(OpAdd, 4'd3, RegImm, RegZero, 12'h800, 12'h001);
    queue_instr(OpSub, 4'd4, RegZero, RegImm, 12'h001, 12'h002);
    queue_instr(OpAnd, 4'd5, 4'd4, RegImm, 12'hFFF, 12'hFFF);
    queue_instr(OpOr, 4'd6, 4'd2, 4'd3, 12'h000, 12'h010);
    queue_instr(OpXor, 4'd7, 4'd2, RegImm, 12'h555, 12'h011);
    queue_instr(OpMul, 4'd8, 4'd3, 4'd3, 12'h000, 12'h012);
    queue_instr(OpMul, 4'd9, 4'd8, 4'd8, 12'h000, 12'h013);
    // shift by 31, then by 4 with the upper amount bits set
    queue_instr(OpSll, 4'd10, 4'd2, RegImm, 12'h7FF, 12'h014);
    queue_instr(OpSra, 4'd11, 4'd10, RegImm, 12'hFE4, 12'h015);
    queue_instr(OpSrl, 4'd12, 4'd10, RegImm, 12'hFE4, 12'h016);
    queue_instr(OpAdd, RegZero, 4'd2, 4'd2, 12'h000, 12'h017);
    queue_instr(OpBeq, RegImm, 4'd2, 4'd2, 12'h123, 12'h020);
    queue_instr(OpBne, 4'd2, 4'd2, 4'd3, 12'h000, 12'h021);
    queue_instr(OpBlt, 4'd2, 4'd3, 4'd2, 12'h000, 12'h022);
    queue_instr(OpBlt, 4'd2, 4'd2, 4'd3, 12'h000, 12'h023);
    queue_instr(OpBgt, RegImm, 4'd2, 4'd3, 12'hABC, 12'h024);
    queue_instr(OpBle, 4'd3, 4'd2, 4'd2, 12'h000, 12'h025);
    queue_instr(OpBge, 4'd2, 4'd3, 4'd2, 12'h000, 12'h026);
    queue_instr(OpJal, RegLink, RegZero, RegZero, 12'h000, 12'hFFF);
    queue_instr(OpJal, 4'd2, RegLink, RegLink, 12'h000, 12'h100);
    queue_instr(OpJal, RegImm, RegZero, RegZero, 12'hFFF, 12'h200);
    queue_instr(OpHalt, RegLink, RegLink, RegLink, 12'hFFF, 12'h234);
    queue_instr(OpUnusedLo, 4'd5, 4'd6, 4'd7, 12'h000, 12'h235);
    queue_instr(OpUnusedMid, 4'd5, 4'd6, 4'd7, 12'h800, 12'h236);
    queue_instr(OpUnusedMax, RegLink, RegLink, RegLink, 12'hFFF, 12'hFFF);
    queue_instr(OpAdd, 4'd13, RegLink, RegLink, 12'h000, 12'h237);

    repeat (RandomItems) instr_backlog.push_back(random_instr());

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (instr_backlog.size() != 0 || in_valid) @(posedge clk);
    while (retire_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("retired %0d of %0d instructions: %0d register writes, %0d redirects, %0d halts",
             n_retired, n_accepted, n_writes, n_redirect, n_halts);
    $display("%0d receiver hold-offs, input stalled for %0d cycles, %0d mismatches",
             n_holds, n_in_stall, mismatches);
    if (mismatches == 0) begin
      $display("risc_instruction_execute_unit verification clean");
    end else begin
      $display("risc_instruction_execute_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/rie_pkg.sv
sv/rie_regfile.sv
sv/rie_exec.sv
sv/risc_instruction_execute_unit.sv
tb/tb_risc_instruction_execute_unit.sv
